// ===== design/svpwm_pkg.sv =====
package svpwm_pkg;

    // fixed field widths
    localparam int PERIOD_W   = 16;
    localparam int KSCALE_W   = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int SECTOR_W   = 3;
    localparam int FRAC_W     = 16;

    // default parameter values
    localparam int VOLTAGE_WIDTH_DEF = 16;
    localparam int COMPARE_WIDTH_DEF = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KSCALE = 1'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4200;
    localparam logic [KSCALE_W-1:0] KSCALE_RESET = 24'd65536;

    // sqrt(3) with 16 fractional bits, and the half-LSB rounding term
    localparam int SQRT3_W = 18;
    localparam logic signed [SQRT3_W-1:0] SQRT3_Q16  = 18'sd113512;
    localparam logic signed [SQRT3_W-1:0] ROUND_HALF = 18'sd32768;

    typedef logic [SECTOR_W-1:0] t_sector;

    localparam t_sector SEC_ZERO = 3'd0;
    localparam t_sector SEC_1    = 3'd1;
    localparam t_sector SEC_2    = 3'd2;
    localparam t_sector SEC_3    = 3'd3;
    localparam t_sector SEC_4    = 3'd4;
    localparam t_sector SEC_5    = 3'd5;
    localparam t_sector SEC_6    = 3'd6;

    // per-item data that rides alongside the divider
    typedef struct packed {
        t_sector             sec;
        logic                ov;
        logic [PERIOD_W-1:0] tx;
        logic [PERIOD_W-1:0] ty;
    } t_side;

endpackage

// ===== design/svpwm_div.sv =====
module svpwm_div #(
    parameter int NW = 43,
    parameter int DW = 28,
    parameter int QW = 16
) (
    input  logic                  i_clk,
    input  logic [QW-1:0]         i_en,
    input  logic [NW-1:0]         i_num_x,
    input  logic [NW-1:0]         i_num_y,
    input  logic [DW-1:0]         i_den,
    input  svpwm_pkg::t_side      i_side,
    output logic [QW-1:0]         o_quo_x,
    output logic [QW-1:0]         o_quo_y,
    output svpwm_pkg::t_side      o_side
);
    import svpwm_pkg::*;

    localparam int RW = DW + QW;

    // one quotient bit per stage, two lanes sharing the divisor
    logic [RW-1:0] r_rem_x [QW];
    logic [RW-1:0] r_rem_y [QW];
    logic [QW-1:0] r_q_x   [QW];
    logic [QW-1:0] r_q_y   [QW];
    logic [DW-1:0] r_den   [QW];
    t_side         r_side  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int SH = QW - 1 - j;
        logic [RW-1:0] w_rem_x, w_rem_y, w_dsh;
        logic [QW-1:0] w_q_x, w_q_y;
        logic [DW-1:0] w_den;
        t_side         w_side;
        logic          w_bx, w_by;

        if (j == 0) begin : g_first
            assign w_rem_x = RW'(i_num_x);
            assign w_rem_y = RW'(i_num_y);
            assign w_q_x   = '0;
            assign w_q_y   = '0;
            assign w_den   = i_den;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_rem_x = r_rem_x[j-1];
            assign w_rem_y = r_rem_y[j-1];
            assign w_q_x   = r_q_x[j-1];
            assign w_q_y   = r_q_y[j-1];
            assign w_den   = r_den[j-1];
            assign w_side  = r_side[j-1];
        end

        assign w_dsh = RW'(w_den) << SH;
        assign w_bx  = (w_rem_x >= w_dsh);
        assign w_by  = (w_rem_y >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem_x[j] <= w_bx ? (w_rem_x - w_dsh) : w_rem_x;
                r_rem_y[j] <= w_by ? (w_rem_y - w_dsh) : w_rem_y;
                r_q_x[j]   <= {w_q_x[QW-2:0], w_bx};
                r_q_y[j]   <= {w_q_y[QW-2:0], w_by};
                r_den[j]   <= w_den;
                r_side[j]  <= w_side;
            end
        end
    end

    assign o_quo_x = r_q_x[QW-1];
    assign o_quo_y = r_q_y[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== design/space_vector_pwm_top.sv =====
// Space vector PWM, seven-segment center-aligned compare generator.
// Input channel (i_in_valid / o_in_ready): one alpha/beta voltage command,
// Q15 signed. Output channel (o_out_valid / i_out_ready): three phase
// compare values in ticks, the sector (0 for a zero vector) and an
// overmodulation flag set when the active times were scaled to fit.
// Config port: i_cfg_we with i_cfg_idx 0 = period_ticks, 1 = k_scale;
// write only while no item is in flight.
// Pipeline: 22 register stages (sqrt3 product, projections and sector
// select, k_scale products, time sum, rescale numerators, 16 restoring
// divide stages with one quotient bit each, final compare assembly). The
// result passes through every stage in turn into the output register; one
// item per cycle is sustained while the receiver accepts results, since
// every stage is fully pipelined.
// Each stage holds only when it is full and the stage after it is held, so
// bubbles collapse and a stalled receiver fills the pipe before the input
// sees backpressure. Reset (synchronous, active low) empties the pipe and
// loads period 4200 and k_scale 65536.
module space_vector_pwm_top #(
    parameter int VOLTAGE_WIDTH = svpwm_pkg::VOLTAGE_WIDTH_DEF,
    parameter int COMPARE_WIDTH = svpwm_pkg::COMPARE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [svpwm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [VOLTAGE_WIDTH-1:0]    i_alpha_voltage,
    input  logic signed [VOLTAGE_WIDTH-1:0]    i_beta_voltage,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [COMPARE_WIDTH-1:0]           o_compare_u,
    output logic [COMPARE_WIDTH-1:0]           o_compare_v,
    output logic [COMPARE_WIDTH-1:0]           o_compare_w,
    output logic [svpwm_pkg::SECTOR_W-1:0]     o_sector,
    output logic                               o_overmodulated
);
    import svpwm_pkg::*;

    localparam int VW = VOLTAGE_WIDTH;
    localparam int PW = VW + SQRT3_W + 1;         // sqrt3 product, signed
    localparam int UW = VW + 4;                   // projections, signed
    localparam int MW = VW + 3;                   // projection magnitude
    localparam int XW = KSCALE_W + MW;            // k_scale product
    localparam int TW = XW - FRAC_W;              // active time
    localparam int SW = TW + 1;                   // time sum
    localparam int NW = TW + PERIOD_W;            // rescale numerator
    localparam int QW = PERIOD_W;                 // rescaled time
    localparam int ST_DIV = 5;
    localparam int NS = ST_DIV + QW + 1;
    localparam int ST_OUT = NS - 1;

    // projection sign patterns {u3>0, u2>0, u1>0}
    localparam logic [2:0] PAT_S1 = 3'b011;
    localparam logic [2:0] PAT_S2 = 3'b001;
    localparam logic [2:0] PAT_S3 = 3'b101;
    localparam logic [2:0] PAT_S4 = 3'b100;
    localparam logic [2:0] PAT_S5 = 3'b110;
    localparam logic [2:0] PAT_S6 = 3'b010;

    // ---------------- configuration ----------------
    logic [PERIOD_W-1:0] r_period;
    logic [KSCALE_W-1:0] r_kscale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_kscale <= KSCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_KSCALE: r_kscale <= i_cfg_data[KSCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage valids and enables ----------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[ST_OUT];

    // ---------------- S1: sqrt3 * alpha, rounded ----------------
    logic signed [PW-1:0] r_p1;
    logic signed [VW-1:0] r_ub1;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_p1  <= PW'(SQRT3_Q16 * PW'(i_alpha_voltage)) + PW'(ROUND_HALF);
            r_ub1 <= i_beta_voltage;
        end
    end

    // ---------------- S2: projections, sector, magnitudes ----------------
    logic signed [UW-1:0] w_u1, w_u2, w_u3;
    logic [2:0]           w_pat;
    t_sector              w_sec2;
    logic signed [UW-1:0] w_mx2, w_my2;

    assign w_u1  = UW'(r_ub1);
    assign w_u2  = UW'(r_p1 >>> FRAC_W) - w_u1;
    assign w_u3  = -w_u2 - (w_u1 <<< 1);
    assign w_pat = {w_u3 > 0, w_u2 > 0, w_u1 > 0};

    always_comb begin
        w_sec2 = SEC_ZERO;
        w_mx2  = '0;
        w_my2  = '0;
        unique case (w_pat)
            PAT_S1: begin w_sec2 = SEC_1; w_mx2 = w_u2;         w_my2 = w_u1 <<< 1;    end
            PAT_S2: begin w_sec2 = SEC_2; w_mx2 = -w_u2;        w_my2 = -w_u3;         end
            PAT_S3: begin w_sec2 = SEC_3; w_mx2 = w_u1 <<< 1;   w_my2 = w_u3;          end
            PAT_S4: begin w_sec2 = SEC_4; w_mx2 = -(w_u1 <<< 1); w_my2 = -w_u2;        end
            PAT_S5: begin w_sec2 = SEC_5; w_mx2 = w_u3;         w_my2 = w_u2;          end
            PAT_S6: begin w_sec2 = SEC_6; w_mx2 = -w_u3;        w_my2 = -(w_u1 <<< 1); end
            default: ;
        endcase
    end

    t_sector       r_sec2;
    logic [MW-1:0] r_mx2, r_my2;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_sec2 <= w_sec2;
            r_mx2  <= w_mx2[MW-1:0];
            r_my2  <= w_my2[MW-1:0];
        end
    end

    // ---------------- S3: k_scale products ----------------
    t_sector       r_sec3;
    logic [XW-1:0] r_px3, r_py3;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_sec3 <= r_sec2;
            r_px3  <= XW'(r_kscale) * XW'(r_mx2);
            r_py3  <= XW'(r_kscale) * XW'(r_my2);
        end
    end

    // ---------------- S4: active times, sum, overmodulation ----------------
    logic [TW-1:0] w_tx4, w_ty4;
    logic [SW-1:0] w_sum4;

    assign w_tx4  = r_px3[XW-1:FRAC_W];
    assign w_ty4  = r_py3[XW-1:FRAC_W];
    assign w_sum4 = SW'(w_tx4) + SW'(w_ty4);

    t_sector       r_sec4;
    logic          r_ov4;
    logic [TW-1:0] r_tx4, r_ty4;
    logic [SW-1:0] r_sum4;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_sec4 <= r_sec3;
            r_ov4  <= (w_sum4 > SW'(r_period));
            r_tx4  <= w_tx4;
            r_ty4  <= w_ty4;
            r_sum4 <= w_sum4;
        end
    end

    // ---------------- S5: rescale numerators ----------------
    logic [NW-1:0] r_nx5, r_ny5;
    logic [SW-1:0] r_den5;
    t_side         r_side5;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_nx5   <= NW'(r_tx4) * NW'(r_period);
            r_ny5   <= NW'(r_ty4) * NW'(r_period);
            r_den5  <= r_sum4;
            // low bits are exact whenever the times are used unscaled
            r_side5 <= '{sec: r_sec4, ov: r_ov4,
                         tx: r_tx4[PERIOD_W-1:0], ty: r_ty4[PERIOD_W-1:0]};
        end
    end

    // ---------------- S6..S21: divide by the original sum ----------------
    logic [QW-1:0] w_qx, w_qy;
    t_side         w_side;

    svpwm_div #(
        .NW (NW),
        .DW (SW),
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_en    (w_en[ST_DIV +: QW]),
        .i_num_x (r_nx5),
        .i_num_y (r_ny5),
        .i_den   (r_den5),
        .i_side  (r_side5),
        .o_quo_x (w_qx),
        .o_quo_y (w_qy),
        .o_side  (w_side)
    );

    // ---------------- S22: compare assembly ----------------
    logic [PERIOD_W-1:0] w_tx, w_ty, w_tz, w_h;
    logic [PERIOD_W:0]   w_sum;
    logic [PERIOD_W+1:0] w_a, w_b, w_c, w_cu, w_cv, w_cw;

    function automatic logic [COMPARE_WIDTH-1:0] clamp_cmp(
        input logic [PERIOD_W+1:0] val,
        input logic [PERIOD_W-1:0] lim
    );
        logic [PERIOD_W-1:0] res;
        res = (val > (PERIOD_W+2)'(lim)) ? lim : val[PERIOD_W-1:0];
        return COMPARE_WIDTH'(res);
    endfunction

    assign w_tx  = w_side.ov ? w_qx : w_side.tx;
    assign w_ty  = w_side.ov ? w_qy : w_side.ty;
    assign w_sum = (PERIOD_W+1)'(w_tx) + (PERIOD_W+1)'(w_ty);
    // no zero time left when the active times were squeezed into the period
    assign w_tz  = w_side.ov ? '0 : PERIOD_W'((PERIOD_W+1)'(r_period) - w_sum);
    assign w_h   = w_tz >> 1;
    assign w_c   = (PERIOD_W+2)'(w_h);
    assign w_b   = w_c + (PERIOD_W+2)'(w_ty);
    assign w_a   = w_b + (PERIOD_W+2)'(w_tx);

    always_comb begin
        case (w_side.sec)
            SEC_1:   begin w_cu = w_a; w_cv = w_b; w_cw = w_c; end
            SEC_2:   begin w_cu = w_b; w_cv = w_a; w_cw = w_c; end
            SEC_3:   begin w_cu = w_c; w_cv = w_a; w_cw = w_b; end
            SEC_4:   begin w_cu = w_c; w_cv = w_b; w_cw = w_a; end
            SEC_5:   begin w_cu = w_b; w_cv = w_c; w_cw = w_a; end
            SEC_6:   begin w_cu = w_a; w_cv = w_c; w_cw = w_b; end
            default: begin w_cu = w_c; w_cv = w_c; w_cw = w_c; end
        endcase
    end

    logic [COMPARE_WIDTH-1:0] r_cu, r_cv, r_cw;
    t_sector                  r_sec;
    logic                     r_ov;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_cu  <= clamp_cmp(w_cu, r_period);
            r_cv  <= clamp_cmp(w_cv, r_period);
            r_cw  <= clamp_cmp(w_cw, r_period);
            r_sec <= w_side.sec;
            r_ov  <= w_side.ov;
        end
    end

    assign o_compare_u     = r_cu;
    assign o_compare_v     = r_cv;
    assign o_compare_w     = r_cw;
    assign o_sector        = r_sec;
    assign o_overmodulated = r_ov;

    // ---------------- assertions ----------------
    // a zero vector has no active time, so it can never overmodulate
    a_zero_no_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sector == SEC_ZERO) |-> !o_overmodulated)
        else $error("zero vector flagged as overmodulated");

    // a zero vector drives all three phases to the same midpoint
    a_zero_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sector == SEC_ZERO) |->
            (o_compare_u == o_compare_v && o_compare_v == o_compare_w))
        else $error("zero vector compares differ");

    // a held output stage keeps its valid, its u compare, its sector and its flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_cu)
            && $stable(r_sec) && $stable(r_ov)))
        else $error("held result changed");

endmodule
